// File: sv/gmh_pkg.sv
// Shared types and constants of the grid mesh height query block.
// Holds widths, register indexes, controller states and the command and
// status bundles between gmh_ctrl and gmh_dp. Depends on nothing.
package gmh_pkg;

  // Default mesh size in cells
  localparam int CELLS_X_DEF = 16;
  localparam int CELLS_Z_DEF = 16;

  // Port widths
  localparam int CELL_W    = 13;
  localparam int VAL_W     = 32;
  localparam int VIDX_W    = 9;
  localparam int CFG_IDX_W = 3;

  // Cell counters cover up to 256 cells on a side
  localparam int CNT_W     = 8;
  localparam int CXW       = CELL_W + CNT_W + 1;  // cell size times cell count

  // Datapath widths, sized for the largest mesh
  localparam int PQ_W      = VAL_W + 1;           // point relative to origin
  localparam int COORD_W   = 40;                  // vertex coordinates
  localparam int ACC_W     = 56;                  // diagonal edge function
  localparam int DIFF_W    = 42;                  // point minus anchor vertex
  localparam int COEF_W    = 48;                  // cell size times height step
  localparam int MAG_A_W   = 47;
  localparam int CHUNK_W   = 16;
  localparam int MUL_STEPS = 3;
  localparam int MAG_B_W   = CHUNK_W * MUL_STEPS;
  localparam int PROD_W    = 88;
  localparam int TERM_W    = PROD_W + 1;
  localparam int NUM_W     = PROD_W + 2;
  localparam int NMAG_W    = PROD_W + 1;
  localparam int WD_W      = 2 * CELL_W;          // cell width times depth
  localparam int DEN_W     = WD_W + 16;
  localparam int QBITS     = 35;                  // quotient bits kept
  localparam int SUM_W     = 38;
  localparam int STEP_W    = 6;

  localparam logic [CELL_W-1:0] CELL_SIZE_RST = 13'd100;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH = 3'd0,
    CFG_CELL_DEPTH = 3'd1,
    CFG_ORIGIN_X   = 3'd2,
    CFG_ORIGIN_Y   = 3'd3,
    CFG_ORIGIN_Z   = 3'd4
  } cfg_idx_t;

  // Height fetch order
  localparam logic [1:0] HSEL_TL = 2'd0;
  localparam logic [1:0] HSEL_TR = 2'd1;
  localparam logic [1:0] HSEL_BL = 2'd2;
  localparam logic [1:0] HSEL_BR = 2'd3;

  localparam logic [STEP_W-1:0] READ_LAST = 6'd4;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_WALK,
    ST_READ,
    ST_COEF,
    ST_LD1,
    ST_MUL1,
    ST_SGN1,
    ST_LD2,
    ST_MUL2,
    ST_SGN2,
    ST_NUM,
    ST_ABS,
    ST_DIVI,
    ST_DIV,
    ST_FIN,
    ST_MISS
  } state_t;

  typedef struct packed {
    logic       clr;
    logic       wr;
    logic       take;
    logic       prep1;
    logic       prep2;
    logic       prep3;
    logic       walk;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       coef;
    logic       mul_load;
    logic       mul_sel;
    logic       mul_step;
    logic       mul_store;
    logic       num;
    logic       abs;
    logic       div_init;
    logic       div_step;
    logic       fin;
    logic       miss;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hit;
    logic last_cell;
  } dp_sts_t;

endpackage

// File: sv/gmh_ctrl.sv
// Controller of the grid mesh height query block.
// Sequences clearing, the cell walk, height fetch, multiply and divide.
// Depends on gmh_pkg.
module gmh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_operation,
  input  gmh_pkg::dp_sts_t sts,
  output logic             busy,
  output gmh_pkg::dp_cmd_t cmd
);

  gmh_pkg::state_t                 state_r, state_nxt;
  logic [gmh_pkg::STEP_W-1:0]      cnt_r, cnt_nxt;

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmh_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      gmh_pkg::ST_CLEAR: begin
        if (sts.clr_done) state_nxt = gmh_pkg::ST_IDLE;
      end
      gmh_pkg::ST_IDLE: begin
        if (start && in_operation == gmh_pkg::OP_QUERY) state_nxt = gmh_pkg::ST_PREP1;
      end
      gmh_pkg::ST_PREP1: state_nxt = gmh_pkg::ST_PREP2;
      gmh_pkg::ST_PREP2: state_nxt = gmh_pkg::ST_PREP3;
      gmh_pkg::ST_PREP3: state_nxt = gmh_pkg::ST_WALK;
      gmh_pkg::ST_WALK: begin
        priority if (sts.hit) begin
          state_nxt = gmh_pkg::ST_READ;
          cnt_nxt   = '0;
        end else if (sts.last_cell) begin
          state_nxt = gmh_pkg::ST_MISS;
        end
      end
      gmh_pkg::ST_READ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gmh_pkg::READ_LAST) state_nxt = gmh_pkg::ST_COEF;
      end
      gmh_pkg::ST_COEF: state_nxt = gmh_pkg::ST_LD1;
      gmh_pkg::ST_LD1: begin
        state_nxt = gmh_pkg::ST_MUL1;
        cnt_nxt   = '0;
      end
      gmh_pkg::ST_MUL1: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gmh_pkg::STEP_W'(gmh_pkg::MUL_STEPS - 1)) state_nxt = gmh_pkg::ST_SGN1;
      end
      gmh_pkg::ST_SGN1: state_nxt = gmh_pkg::ST_LD2;
      gmh_pkg::ST_LD2: begin
        state_nxt = gmh_pkg::ST_MUL2;
        cnt_nxt   = '0;
      end
      gmh_pkg::ST_MUL2: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gmh_pkg::STEP_W'(gmh_pkg::MUL_STEPS - 1)) state_nxt = gmh_pkg::ST_SGN2;
      end
      gmh_pkg::ST_SGN2: state_nxt = gmh_pkg::ST_NUM;
      gmh_pkg::ST_NUM:  state_nxt = gmh_pkg::ST_ABS;
      gmh_pkg::ST_ABS:  state_nxt = gmh_pkg::ST_DIVI;
      gmh_pkg::ST_DIVI: begin
        state_nxt = gmh_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      gmh_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == gmh_pkg::STEP_W'(gmh_pkg::QBITS - 1)) state_nxt = gmh_pkg::ST_FIN;
      end
      gmh_pkg::ST_FIN:  state_nxt = gmh_pkg::ST_IDLE;
      gmh_pkg::ST_MISS: state_nxt = gmh_pkg::ST_IDLE;
      default:          state_nxt = gmh_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd  = '0;
    busy = (state_r != gmh_pkg::ST_IDLE);
    unique case (state_r)
      gmh_pkg::ST_CLEAR: cmd.clr = 1'b1;
      gmh_pkg::ST_IDLE: begin
        if (start) begin
          if (in_operation == gmh_pkg::OP_QUERY) cmd.take = 1'b1;
          else cmd.wr = 1'b1;
        end
      end
      gmh_pkg::ST_PREP1: cmd.prep1 = 1'b1;
      gmh_pkg::ST_PREP2: cmd.prep2 = 1'b1;
      gmh_pkg::ST_PREP3: cmd.prep3 = 1'b1;
      gmh_pkg::ST_WALK:  cmd.walk  = 1'b1;
      gmh_pkg::ST_READ: begin
        cmd.rd_en   = (cnt_r != gmh_pkg::READ_LAST);
        cmd.rd_sel  = cnt_r[1:0];
        cmd.cap_en  = (cnt_r != '0);
        cmd.cap_sel = 2'(cnt_r - 1'b1);
      end
      gmh_pkg::ST_COEF: cmd.coef = 1'b1;
      gmh_pkg::ST_LD1:  cmd.mul_load = 1'b1;
      gmh_pkg::ST_MUL1: cmd.mul_step = 1'b1;
      gmh_pkg::ST_SGN1: cmd.mul_store = 1'b1;
      gmh_pkg::ST_LD2: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = 1'b1;
      end
      gmh_pkg::ST_MUL2: cmd.mul_step = 1'b1;
      gmh_pkg::ST_SGN2: begin
        cmd.mul_store = 1'b1;
        cmd.mul_sel   = 1'b1;
      end
      gmh_pkg::ST_NUM:  cmd.num      = 1'b1;
      gmh_pkg::ST_ABS:  cmd.abs      = 1'b1;
      gmh_pkg::ST_DIVI: cmd.div_init = 1'b1;
      gmh_pkg::ST_DIV:  cmd.div_step = 1'b1;
      gmh_pkg::ST_FIN:  cmd.fin      = 1'b1;
      gmh_pkg::ST_MISS: cmd.miss     = 1'b1;
      default:          cmd          = '0;
    endcase
  end

endmodule

// File: sv/gmh_dp.sv
// Datapath of the grid mesh height query block: configuration registers,
// height memory, cell walk, sequential multiplier and restoring divider.
// Depends on gmh_pkg; driven by gmh_ctrl through dp_cmd_t.
module gmh_dp #(
  parameter int CELLS_X = gmh_pkg::CELLS_X_DEF,
  parameter int CELLS_Z = gmh_pkg::CELLS_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmh_pkg::VAL_W-1:0]         cfg_wdata,
  input  logic [gmh_pkg::VIDX_W-1:0]        in_vertex_index,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_vertex_height,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_x,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_y,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_z,
  input  gmh_pkg::dp_cmd_t                  cmd,
  output gmh_pkg::dp_sts_t                  sts,
  output logic                              out_valid,
  output logic signed [gmh_pkg::VAL_W-1:0]  out_ground_height,
  output logic                              out_on_mesh
);

  localparam int VROW  = CELLS_X + 1;
  localparam int NVERT = (CELLS_X + 1) * (CELLS_Z + 1);
  localparam int VA_W  = $clog2(NVERT);
  localparam int IW    = ((VA_W > gmh_pkg::VIDX_W) ? VA_W : gmh_pkg::VIDX_W) + 1;
  localparam int KDIFF = CELLS_Z - CELLS_X;
  localparam int KK_W  = gmh_pkg::WD_W + 10;
  localparam int CDP_W = gmh_pkg::CELL_W + gmh_pkg::PQ_W + 1;
  localparam int HD_W  = gmh_pkg::VAL_W + 1;
  localparam int SUM_W = gmh_pkg::SUM_W;
  localparam int CW    = gmh_pkg::COORD_W;
  localparam int AW    = gmh_pkg::ACC_W;
  localparam int DW    = gmh_pkg::DIFF_W;
  localparam int QB    = gmh_pkg::QBITS;
  localparam int DENW  = gmh_pkg::DEN_W;
  localparam logic signed [SUM_W-1:0] SAT_HI = 38'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO = -38'sd2147483648;

  // Configuration registers
  logic [gmh_pkg::CELL_W-1:0]        cw_r, cd_r;
  logic signed [gmh_pkg::VAL_W-1:0]  ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= gmh_pkg::CELL_SIZE_RST;
      cd_r <= gmh_pkg::CELL_SIZE_RST;
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
    end else if (cfg_we) begin
      unique case (gmh_pkg::cfg_idx_t'(cfg_index))
        gmh_pkg::CFG_CELL_WIDTH: cw_r <= cfg_wdata[gmh_pkg::CELL_W-1:0];
        gmh_pkg::CFG_CELL_DEPTH: cd_r <= cfg_wdata[gmh_pkg::CELL_W-1:0];
        gmh_pkg::CFG_ORIGIN_X:   ox_r <= $signed(cfg_wdata);
        gmh_pkg::CFG_ORIGIN_Y:   oy_r <= $signed(cfg_wdata);
        gmh_pkg::CFG_ORIGIN_Z:   oz_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Height memory, cleared by a sweep after reset
  logic signed [gmh_pkg::VAL_W-1:0]  mem [NVERT];
  logic [VA_W-1:0]                   clr_cnt_r;
  logic [VA_W-1:0]                   v0_r;
  logic [VA_W-1:0]                   raddr;
  logic [VA_W-1:0]                   waddr;
  logic signed [gmh_pkg::VAL_W-1:0]  wdata;
  logic                              we;
  logic                              idx_ok;
  logic signed [gmh_pkg::VAL_W-1:0]  rdata_r;

  assign idx_ok = IW'(in_vertex_index) < IW'(NVERT);
  assign we     = cmd.clr || (cmd.wr && idx_ok);
  assign waddr  = cmd.clr ? clr_cnt_r : VA_W'(in_vertex_index);
  assign wdata  = cmd.clr ? '0 : in_vertex_height;

  always_comb begin
    unique case (cmd.rd_sel)
      gmh_pkg::HSEL_TL: raddr = v0_r;
      gmh_pkg::HSEL_TR: raddr = v0_r + VA_W'(1);
      gmh_pkg::HSEL_BL: raddr = v0_r + VA_W'(VROW);
      gmh_pkg::HSEL_BR: raddr = v0_r + VA_W'(VROW + 1);
      default:          raddr = v0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign sts.clr_done = (clr_cnt_r == VA_W'(NVERT - 1));

  // Query capture and setup
  logic signed [gmh_pkg::PQ_W-1:0]   px_r, pz_r;
  logic signed [gmh_pkg::VAL_W-1:0]  qy_r;
  logic signed [CDP_W-1:0]           cdpx_r, cwpz_r;
  logic [gmh_pkg::WD_W-1:0]          cwcd_r;
  logic [gmh_pkg::CXW-1:0]           cwcx_r, cdcz_r;
  logic signed [CW-1:0]              sx_r, sz_r;
  logic signed [CDP_W:0]             p_r;
  logic signed [KK_W-1:0]            kk_r;
  logic [DENW-1:0]                   den_r;
  logic signed [CW-1:0]              xl0_r, xr0_r, zt0_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_r <= gmh_pkg::PQ_W'(in_query_x) - gmh_pkg::PQ_W'(ox_r);
      pz_r <= gmh_pkg::PQ_W'(in_query_z) - gmh_pkg::PQ_W'(oz_r);
      qy_r <= in_query_y;
    end
    if (cmd.prep1) begin
      cdpx_r <= CDP_W'($signed({1'b0, cd_r})) * CDP_W'(px_r);
      cwpz_r <= CDP_W'($signed({1'b0, cw_r})) * CDP_W'(pz_r);
      cwcd_r <= gmh_pkg::WD_W'(cw_r) * gmh_pkg::WD_W'(cd_r);
      cwcx_r <= gmh_pkg::CXW'(cw_r) * gmh_pkg::CXW'(CELLS_X);
      cdcz_r <= gmh_pkg::CXW'(cd_r) * gmh_pkg::CXW'(CELLS_Z);
      sx_r   <= $signed(CW'({cw_r, 16'b0}));
      sz_r   <= $signed(CW'({cd_r, 16'b0}));
    end
    if (cmd.prep2) begin
      p_r   <= (CDP_W + 1)'(cdpx_r) + (CDP_W + 1)'(cwpz_r);
      kk_r  <= KK_W'($signed({1'b0, cwcd_r})) * KK_W'(KDIFF);
      den_r <= {cwcd_r, 16'b0};
      xl0_r <= -$signed(CW'({cwcx_r, 15'b0}));
      zt0_r <= $signed(CW'({cdcz_r, 15'b0}));
    end
    if (cmd.prep3) begin
      xr0_r <= xl0_r + sx_r;
    end
  end

  // Cell walk: edge tests against the current cell
  logic [gmh_pkg::CNT_W-1:0]  c_r, r_r;
  logic signed [CW-1:0]       xl_r, xr_r, zt_r, zb_r;
  logic signed [AW-1:0]       a_r, arow_r, den_s, a0;
  logic signed [CW-1:0]       pxe, pze;
  logic                       right_hit, left_hit, row_end;
  logic                       tri_r;
  logic signed [DW-1:0]       dx_r, dz_r;

  assign pxe   = CW'(px_r);
  assign pze   = CW'(pz_r);
  assign den_s = $signed(AW'(den_r));
  assign a0    = AW'(p_r) - (AW'(kk_r) <<< 15);

  assign right_hit = (cd_r == '0 || pxe <= xr_r) && !a_r[AW-1] &&
                     (cw_r == '0 || pze <= zt_r);
  assign left_hit  = (cd_r == '0 || pxe >= xl_r) && (a_r[AW-1] || a_r == '0) &&
                     (cw_r == '0 || pze >= zb_r);
  assign row_end   = (c_r == gmh_pkg::CNT_W'(CELLS_X - 1));

  assign sts.hit       = right_hit || left_hit;
  assign sts.last_cell = row_end && (r_r == gmh_pkg::CNT_W'(CELLS_Z - 1));

  always_ff @(posedge clk) begin
    if (cmd.prep3) begin
      c_r    <= '0;
      r_r    <= '0;
      v0_r   <= '0;
      xl_r   <= xl0_r;
      xr_r   <= xl0_r + sx_r;
      zt_r   <= zt0_r;
      zb_r   <= zt0_r - sz_r;
      a_r    <= a0;
      arow_r <= a0;
    end else if (cmd.walk) begin
      if (right_hit || left_hit) begin
        // Hold the cell; keep offsets from the triangle's anchor vertex
        tri_r <= right_hit;
        dx_r  <= right_hit ? DW'(pxe) - DW'(xr_r) : DW'(pxe) - DW'(xl_r);
        dz_r  <= right_hit ? DW'(pze) - DW'(zt_r) : DW'(pze) - DW'(zb_r);
      end else if (row_end) begin
        c_r    <= '0;
        r_r    <= r_r + 1'b1;
        v0_r   <= v0_r + VA_W'(2);
        xl_r   <= xl0_r;
        xr_r   <= xr0_r;
        zt_r   <= zt_r - sz_r;
        zb_r   <= zb_r - sz_r;
        arow_r <= arow_r + den_s;
        a_r    <= arow_r + den_s;
      end else begin
        c_r  <= c_r + 1'b1;
        v0_r <= v0_r + VA_W'(1);
        xl_r <= xl_r + sx_r;
        xr_r <= xr_r + sx_r;
        a_r  <= a_r - den_s;
      end
    end
  end

  // Height capture and slope coefficients
  logic signed [gmh_pkg::VAL_W-1:0]   h0_r, h1_r, h2_r, h3_r, base_r;
  logic signed [HD_W-1:0]             e1, e2;
  logic signed [gmh_pkg::COEF_W-1:0]  m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      unique case (cmd.cap_sel)
        gmh_pkg::HSEL_TL: h0_r <= rdata_r;
        gmh_pkg::HSEL_TR: h1_r <= rdata_r;
        gmh_pkg::HSEL_BL: h2_r <= rdata_r;
        gmh_pkg::HSEL_BR: h3_r <= rdata_r;
        default: ;
      endcase
    end
  end

  assign e1 = tri_r ? HD_W'(h1_r) - HD_W'(h0_r) : HD_W'(h3_r) - HD_W'(h2_r);
  assign e2 = tri_r ? HD_W'(h3_r) - HD_W'(h1_r) : HD_W'(h2_r) - HD_W'(h0_r);

  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      base_r <= tri_r ? h1_r : h2_r;
      m1_r   <= gmh_pkg::COEF_W'($signed({1'b0, cd_r})) * gmh_pkg::COEF_W'(e1);
      m2_r   <= gmh_pkg::COEF_W'($signed({1'b0, cw_r})) * gmh_pkg::COEF_W'(e2);
    end
  end

  // Sequential multiplier: 16 bits of the offset per cycle, top chunk first
  logic [gmh_pkg::MAG_A_W-1:0]        ma_r;
  logic [gmh_pkg::MAG_B_W-1:0]        mb_r;
  logic                               msgn_r;
  logic [gmh_pkg::PROD_W-1:0]         acc_r;
  logic signed [gmh_pkg::COEF_W-1:0]  m_sel, m_abs;
  logic signed [DW-1:0]               d_sel, d_abs;
  logic signed [gmh_pkg::TERM_W-1:0]  tv, t1_r, t2_r;
  logic [gmh_pkg::CHUNK_W-1:0]        b_top;

  assign m_sel = cmd.mul_sel ? m2_r : m1_r;
  assign d_sel = cmd.mul_sel ? dz_r : dx_r;
  assign m_abs = m_sel[gmh_pkg::COEF_W-1] ? -m_sel : m_sel;
  assign d_abs = d_sel[DW-1] ? -d_sel : d_sel;
  assign b_top = mb_r[gmh_pkg::MAG_B_W-1 -: gmh_pkg::CHUNK_W];
  assign tv    = $signed({1'b0, acc_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_r   <= gmh_pkg::MAG_A_W'($unsigned(m_abs));
      mb_r   <= gmh_pkg::MAG_B_W'($unsigned(d_abs));
      msgn_r <= m_sel[gmh_pkg::COEF_W-1] ^ d_sel[DW-1];
      acc_r  <= '0;
    end else if (cmd.mul_step) begin
      acc_r <= (acc_r << gmh_pkg::CHUNK_W) +
               gmh_pkg::PROD_W'(ma_r) * gmh_pkg::PROD_W'(b_top);
      mb_r  <= mb_r << gmh_pkg::CHUNK_W;
    end
    if (cmd.mul_store) begin
      if (cmd.mul_sel) t2_r <= msgn_r ? -tv : tv;
      else t1_r <= msgn_r ? -tv : tv;
    end
  end

  // Numerator sign and magnitude
  logic signed [gmh_pkg::NUM_W-1:0]  num_r;
  logic                              nneg_r;
  logic [gmh_pkg::NMAG_W-1:0]        nmag_r;

  always_ff @(posedge clk) begin
    if (cmd.num) num_r <= gmh_pkg::NUM_W'(t1_r) - gmh_pkg::NUM_W'(t2_r);
    if (cmd.abs) begin
      nneg_r <= num_r[gmh_pkg::NUM_W-1];
      nmag_r <= gmh_pkg::NMAG_W'(num_r[gmh_pkg::NUM_W-1] ? -num_r : num_r);
    end
  end

  // Restoring divider, one quotient bit per cycle; large quotients saturate
  logic [DENW-1:0]   rem_r;
  logic [QB-1:0]     nlo_r, q_r;
  logic              ovf_r;
  logic [DENW:0]     r2;

  assign r2 = {rem_r, nlo_r[QB-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      ovf_r <= nmag_r[gmh_pkg::NMAG_W-1:QB] >= (gmh_pkg::NMAG_W - QB)'(den_r);
      rem_r <= nmag_r[QB +: DENW];
      nlo_r <= nmag_r[QB-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      nlo_r <= nlo_r << 1;
      if (r2 >= {1'b0, den_r}) begin
        rem_r <= DENW'(r2 - {1'b0, den_r});
        q_r   <= {q_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= r2[DENW-1:0];
        q_r   <= {q_r[QB-2:0], 1'b0};
      end
    end
  end

  // Final sum, saturate, and result strobe
  logic [QB-1:0]              dmag;
  logic signed [SUM_W-1:0]    delta, sum;

  assign dmag  = (den_r == '0) ? '0 : (ovf_r ? '1 : q_r);
  assign delta = nneg_r ? -$signed(SUM_W'(dmag)) : $signed(SUM_W'(dmag));
  assign sum   = SUM_W'(oy_r) + SUM_W'(base_r) + delta;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.fin || cmd.miss;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_on_mesh <= 1'b1;
      priority if (sum > SAT_HI) out_ground_height <= SAT_HI[gmh_pkg::VAL_W-1:0];
      else if (sum < SAT_LO) out_ground_height <= SAT_LO[gmh_pkg::VAL_W-1:0];
      else out_ground_height <= sum[gmh_pkg::VAL_W-1:0];
    end else if (cmd.miss) begin
      out_on_mesh       <= 1'b0;
      out_ground_height <= qy_r;
    end
  end

endmodule

// File: sv/grid_mesh_height_query_core.sv
// Top level of the grid mesh height query block.
// Joins the controller gmh_ctrl and the datapath gmh_dp; depends on gmh_pkg.
//
//   channel   handshake         payload
//   input     start / busy      in_operation, in_vertex_index, in_vertex_height,
//                               in_query_x, in_query_y, in_query_z
//   result    out_valid strobe  out_ground_height, out_on_mesh
//   config    cfg_we            cfg_index, cfg_wdata
//
// A height write gives no result and does not raise busy. A query holds busy
// through three setup steps, the row-order walk that tests one cell per cycle
// (CELLS_X*CELLS_Z cells at most), then on a hit the height fetch,
// coefficients and two 3-step 16-bit-per-cycle multiplies, numerator and
// magnitude, the restoring divider (an init step, then one step per quotient
// bit) and a final step. On a miss the walk is followed by the MISS state.
// The result strobe follows the last busy cycle. After reset the block clears
// the (CELLS_X+1)*(CELLS_Z+1) height entries, one per cycle, with busy high.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module grid_mesh_height_query_core #(
  parameter int CELLS_X = gmh_pkg::CELLS_X_DEF,
  parameter int CELLS_Z = gmh_pkg::CELLS_Z_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [gmh_pkg::VIDX_W-1:0]        in_vertex_index,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_vertex_height,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_x,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_y,
  input  logic signed [gmh_pkg::VAL_W-1:0]  in_query_z,
  output logic                              out_valid,
  output logic signed [gmh_pkg::VAL_W-1:0]  out_ground_height,
  output logic                              out_on_mesh,
  input  logic                              cfg_we,
  input  logic [gmh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gmh_pkg::VAL_W-1:0]         cfg_wdata
);

  gmh_pkg::dp_cmd_t cmd;
  gmh_pkg::dp_sts_t sts;

  // Sequencer
  gmh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .busy         (busy),
    .cmd          (cmd)
  );

  // Arithmetic and storage
  gmh_dp #(
    .CELLS_X (CELLS_X),
    .CELLS_Z (CELLS_Z)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_vertex_index   (in_vertex_index),
    .in_vertex_height  (in_vertex_height),
    .in_query_x        (in_query_x),
    .in_query_y        (in_query_y),
    .in_query_z        (in_query_z),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ground_height (out_ground_height),
    .out_on_mesh       (out_on_mesh)
  );

endmodule

// File: dv/tb_grid_mesh_height_query_core.sv
// Self-checking testbench for grid_mesh_height_query_core: directed table, then
// random phases of height writes and queries under several mesh settings.
// Depends on gmh_pkg and the RTL only; expected results come from a local predictor.
module tb_grid_mesh_height_query_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NX      = gmh_pkg::CELLS_X_DEF;
  localparam int NZ      = gmh_pkg::CELLS_Z_DEF;
  localparam int ROWLEN  = NX + 1;
  localparam int NVERT   = (NX + 1) * (NZ + 1);
  localparam int SETTLE  = 350;
  localparam int LIMIT   = 2000000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  typedef struct {
    logic signed [31:0] ground;
    logic               on_mesh;
  } height_result_t;

  typedef struct {
    logic               op;
    logic [8:0]         vidx;
    logic signed [31:0] vh;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               typed;
    logic signed [31:0] ground;
    logic               on_mesh;
  } dir_row_t;

  logic clk, rst_n, start, busy;
  logic in_operation;
  logic [gmh_pkg::VIDX_W-1:0] in_vertex_index;
  logic signed [gmh_pkg::VAL_W-1:0] in_vertex_height, in_query_x, in_query_y, in_query_z;
  logic out_valid, out_on_mesh;
  logic signed [gmh_pkg::VAL_W-1:0] out_ground_height;
  logic cfg_we;
  logic [gmh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gmh_pkg::VAL_W-1:0] cfg_wdata;

  // typed expectation travelling with a directed transaction
  logic typed_q;
  logic signed [31:0] typed_ground;
  logic typed_on;

  // predictor state
  logic signed [31:0] mesh_height [NVERT];
  logic [12:0] pw, pd;
  logic signed [31:0] pox, poy, poz;

  height_result_t pending_heights[$];
  int errors, queries_sent, writes_sent, hits_seen, results_seen;
  longint cycles;
  int sender_idle;

  grid_mesh_height_query_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_vertex_index(in_vertex_index),
    .in_vertex_height(in_vertex_height), .in_query_x(in_query_x),
    .in_query_y(in_query_y), .in_query_z(in_query_z),
    .out_valid(out_valid), .out_ground_height(out_ground_height),
    .out_on_mesh(out_on_mesh),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Interpolate the ground height at a point from the predictor's mesh copy
  function automatic height_result_t ground_at(logic signed [31:0] qx,
                                               logic signed [31:0] qy,
                                               logic signed [31:0] qz);
    height_result_t res;
    logic signed [127:0] cw, cd, px, pz, xl, xr, zt, zb, h0, h1, h2, h3;
    logic signed [127:0] d0x, d0z, d1x, d1z, d2x, d2z, d3x, d3z;
    logic signed [127:0] num, base, den, q, lim, g;
    logic hit;
    int v0;
    cw  = $signed({115'b0, pw});
    cd  = $signed({115'b0, pd});
    px  = 128'(qx) - 128'(pox);
    pz  = 128'(qz) - 128'(poz);
    den = cw * cd * 128'sd65536;
    lim = 128'sd1 <<< 62;
    hit = 1'b0;
    g   = 0;
    for (int r = 0; r < NZ && !hit; r++) begin
      for (int c = 0; c < NX && !hit; c++) begin
        v0 = r * ROWLEN + c;
        h0 = 128'(mesh_height[v0]);
        h1 = 128'(mesh_height[v0 + 1]);
        h2 = 128'(mesh_height[v0 + ROWLEN]);
        h3 = 128'(mesh_height[v0 + ROWLEN + 1]);
        xl = (2 * cw * c - cw * NX) * 128'sd32768;
        xr = (2 * cw * (c + 1) - cw * NX) * 128'sd32768;
        zt = (cd * NZ - 2 * cd * r) * 128'sd32768;
        zb = (cd * NZ - 2 * cd * (r + 1)) * 128'sd32768;
        d0x = px - xl; d0z = pz - zt;
        d1x = px - xr; d1z = pz - zt;
        d2x = px - xl; d2z = pz - zb;
        d3x = px - xr; d3z = pz - zb;
        // right triangle first, then left; inside means all edges >= 0
        if (-cd * d3x >= 0 && cd * d0x + cw * d0z >= 0 && -cw * d1z >= 0) begin
          num = cd * (h1 - h0) * d1x - cw * (h3 - h1) * d1z;
          base = h1;
          hit = 1'b1;
        end else if (cd * d0x >= 0 && -cd * d3x - cw * d3z >= 0 && cw * d2z >= 0) begin
          num = cd * (h3 - h2) * d2x - cw * (h2 - h0) * d2z;
          base = h2;
          hit = 1'b1;
        end
        if (hit) begin
          q = (den != 0) ? num / den : 128'sd0;
          if (q > lim) q = lim;
          if (q < -lim) q = -lim;
          g = 128'(poy) + base + q;
        end
      end
    end
    if (hit) begin
      if (g > 128'(SMAX)) g = 128'(SMAX);
      if (g < 128'(SMIN)) g = 128'(SMIN);
      res.ground  = g[31:0];
      res.on_mesh = 1'b1;
    end else begin
      res.ground  = qy;
      res.on_mesh = 1'b0;
    end
    return res;
  endfunction

  // Follow accepted transactions and register writes; check every result
  always @(posedge clk) begin
    height_result_t want;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (pending_heights.size() == 0) begin
          $error("result with none expected: ground_height %0d on_mesh %0b",
                 out_ground_height, out_on_mesh);
          errors++;
        end else begin
          want = pending_heights.pop_front();
          if (out_ground_height !== want.ground) begin
            $error("ground_height: expected %0d, got %0d", want.ground, out_ground_height);
            errors++;
          end
          if (out_on_mesh !== want.on_mesh) begin
            $error("on_mesh: expected %0b, got %0b", want.on_mesh, out_on_mesh);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (gmh_pkg::cfg_idx_t'(cfg_index))
          gmh_pkg::CFG_CELL_WIDTH: pw  <= cfg_wdata[12:0];
          gmh_pkg::CFG_CELL_DEPTH: pd  <= cfg_wdata[12:0];
          gmh_pkg::CFG_ORIGIN_X:   pox <= cfg_wdata;
          gmh_pkg::CFG_ORIGIN_Y:   poy <= cfg_wdata;
          gmh_pkg::CFG_ORIGIN_Z:   poz <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_operation == gmh_pkg::OP_WRITE) begin
          writes_sent <= writes_sent + 1;
          if (in_vertex_index < NVERT) mesh_height[in_vertex_index] <= in_vertex_height;
        end else begin
          queries_sent <= queries_sent + 1;
          want = ground_at(in_query_x, in_query_y, in_query_z);
          if (typed_q) begin
            want.ground  = typed_ground;
            want.on_mesh = typed_on;
          end
          if (want.on_mesh) hits_seen <= hits_seen + 1;
          pending_heights.push_back(want);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it
  task automatic send_item(dir_row_t t);
    int gap;
    gap = 0;
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_operation     <= t.op;
    in_vertex_index  <= t.vidx;
    in_vertex_height <= t.vh;
    in_query_x       <= t.qx;
    in_query_y       <= t.qy;
    in_query_z       <= t.qz;
    typed_q          <= t.typed;
    typed_ground     <= t.ground;
    typed_on         <= t.on_mesh;
    do @(posedge clk); while (busy);
  endtask

  // Drain outstanding queries, then give writes time to finish
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_heights.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drive one register write and wait for the clock edge that takes it; the caller drops cfg_we after the last
  task automatic write_reg(gmh_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  function automatic dir_row_t query_row(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    dir_row_t t;
    t = '{op: gmh_pkg::OP_QUERY, vidx: 9'($urandom), vh: $urandom, qx: x, qy: y, qz: z,
          typed: 1'b0, ground: 0, on_mesh: 1'b0};
    return t;
  endfunction

  function automatic dir_row_t write_row(logic [8:0] idx, logic signed [31:0] h);
    dir_row_t t;
    t = '{op: gmh_pkg::OP_WRITE, vidx: idx, vh: h, qx: $urandom, qy: $urandom,
          qz: $urandom, typed: 1'b0, ground: 0, on_mesh: 1'b0};
    return t;
  endfunction

  // Random transaction: mostly queries aimed at the mesh, some writes
  function automatic dir_row_t random_row();
    longint spanx, spanz;
    dir_row_t t;
    int pick;
    spanx = longint'(pw) * (NX / 2 + 1) * 65536;
    spanz = longint'(pd) * (NZ / 2 + 1) * 65536;
    pick  = $urandom_range(99);
    if (pick < 35) begin
      t = write_row($urandom_range(99) < 8 ? 9'($urandom_range(NVERT, 511))
                                           : 9'($urandom_range(NVERT - 1)),
                    $urandom_range(3) == 0 ? 32'($urandom)
                                           : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
    end else if (pick < 90) begin
      t = query_row(32'(longint'(pox) + $signed(32'($urandom)) % (spanx + 1)),
                    $urandom,
                    32'(longint'(poz) + $signed(32'($urandom)) % (spanz + 1)));
    end else begin
      t = query_row($urandom, $urandom, $urandom);
    end
    return t;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t t;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_operation = gmh_pkg::OP_WRITE; in_vertex_index = '0; in_vertex_height = '0;
    in_query_x = '0; in_query_y = '0; in_query_z = '0;
    typed_q = 1'b0; typed_ground = '0; typed_on = 1'b0;
    errors = 0; queries_sent = 0; writes_sent = 0; hits_seen = 0; results_seen = 0;
    cycles = 0; sender_idle = 0;
    pw = 13'd100; pd = 13'd100; pox = 0; poy = 0; poz = 0;
    foreach (mesh_height[i]) mesh_height[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: flat mesh after reset, off-mesh corners, height extremes,
    // out-of-range writes, then queries near the extreme vertices
    t = query_row(0, 32'sd12345, 0);              t.typed = 1'b1; t.ground = 0;
    dir_rows.push_back(t);
    t = query_row(SMAX, 32'sd777, 0);             t.typed = 1'b1; t.ground = 32'sd777;
    dir_rows.push_back(t);
    t = query_row(SMIN, SMIN, SMIN);              t.typed = 1'b1; t.ground = SMIN;
    dir_rows.push_back(t);
    t = query_row(0, SMAX, SMAX);                 t.typed = 1'b1; t.ground = SMAX;
    dir_rows.push_back(t);
    t = query_row(-800 * 65536, -5, 800 * 65536);
    t.typed = 1'b1; t.ground = 0; t.on_mesh = 1'b1;
    dir_rows.push_back(t);
    t = query_row(800 * 65536, -5, -800 * 65536);
    t.typed = 1'b1; t.ground = 0; t.on_mesh = 1'b1;
    dir_rows.push_back(t);
    dir_rows[0].on_mesh = 1'b1;
    dir_rows.push_back(write_row(0, SMAX));
    dir_rows.push_back(write_row(9'(NVERT - 1), SMIN));
    dir_rows.push_back(write_row(9'(NVERT), SMAX));
    dir_rows.push_back(write_row(9'd511, SMIN));
    dir_rows.push_back(write_row(9'd144, 32'sd655360));
    dir_rows.push_back(write_row(9'd1, -32'sd1));
    dir_rows.push_back(query_row(-790 * 65536, 0, 790 * 65536));
    dir_rows.push_back(query_row(-800 * 65536, 0, 800 * 65536));
    dir_rows.push_back(query_row(790 * 65536, 0, -790 * 65536));
    dir_rows.push_back(query_row(0, 0, 0));
    dir_rows.push_back(query_row(3 * 65536 + 1, 0, -7 * 65536 - 3));
    dir_rows.push_back(query_row(-750 * 65536, 0, 750 * 65536));
    dir_rows.push_back(query_row(801 * 65536, 9, 0));
    foreach (dir_rows[i]) send_item(dir_rows[i]);
    wait_idle();

    // random phases through cell sizes and origins, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, 32'd1);
          write_reg(gmh_pkg::CFG_CELL_DEPTH, 32'd1);
        end
        1: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, 32'd4096);
          write_reg(gmh_pkg::CFG_CELL_DEPTH, 32'd4096);
        end
        2: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, 32'd0);
          write_reg(gmh_pkg::CFG_CELL_DEPTH, 32'd37);
        end
        3: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, 32'd53);
          write_reg(gmh_pkg::CFG_CELL_DEPTH, 32'd0);
        end
        4: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, $urandom);
          write_reg(gmh_pkg::CFG_CELL_DEPTH, $urandom);
        end
        default: begin
          write_reg(gmh_pkg::CFG_CELL_WIDTH, $urandom_range(1, 4096));
          write_reg(gmh_pkg::CFG_CELL_DEPTH, $urandom_range(1, 4096));
        end
      endcase
      write_reg(gmh_pkg::CFG_ORIGIN_X,
                ph == 1 ? 32'h8000_0000 : ph == 2 ? 32'h7fff_ffff : $urandom);
      write_reg(gmh_pkg::CFG_ORIGIN_Y,
                ph == 5 ? 32'h7fff_ffff : ph == 6 ? 32'h8000_0000 :
                ph == 0 ? 32'd0 : $urandom);
      write_reg(gmh_pkg::CFG_ORIGIN_Z,
                ph == 1 ? 32'h7fff_ffff : ph == 2 ? 32'h8000_0000 : $urandom);
      cfg_we <= 1'b0;
      case (ph % 4)
        0: sender_idle = 0;
        1: sender_idle = 63;
        2: sender_idle = 0;
        default: sender_idle = 28;
      endcase
      for (int n = 0; n < 104; n++) begin
        t = random_row();
        send_item(t);
      end
      wait_idle();
    end

    $display("run covered %0d queries (%0d on mesh) and %0d height writes",
             queries_sent, hits_seen, writes_sent);
    $display("eight mesh settings incl. zero and largest cell sizes; %0d results checked",
             results_seen);
    if (errors == 0 && pending_heights.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
